FILE: hdl/lfrf_pkg.sv
// Shared types and constants for the longest fill run finder.
package lfrf_pkg;

   localparam int ADDRESS_BITS = 23;
   localparam int BANK_BYTES   = 16384;
   localparam int BANK_BITS    = $clog2(BANK_BYTES);
   localparam int RANGE_BITS   = ADDRESS_BITS + 1;
   localparam int LENGTH_BITS  = ADDRESS_BITS + 1;
   localparam int BYTE_BITS    = 8;

   localparam int SCAN_BANK_BITS = 10;
   localparam int ROM_BYTES_BITS = 24;
   localparam int CSR_DATA_BITS  = 24;

   localparam logic [BYTE_BITS-1:0] FILL_ZERO = 8'h00;
   localparam logic [BYTE_BITS-1:0] FILL_ONES = 8'hFF;

   localparam logic [SCAN_BANK_BITS-1:0] SCAN_BANK_RESET = '1;
   localparam logic [ROM_BYTES_BITS-1:0] ROM_BYTES_RESET = 24'd32768;

   typedef enum logic [0:0] {
      CSR_SCAN_BANK = 1'b0,
      CSR_ROM_BYTES = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [ADDRESS_BITS-1:0] rom_address;
      logic [BYTE_BITS-1:0]    rom_byte;
   } req_type;

   typedef struct packed {
      logic [ADDRESS_BITS-1:0] longest_start;
      logic [LENGTH_BITS-1:0]  longest_size;
   } rsp_type;

   // Scan range decoded from the configuration registers.
   typedef struct packed {
      logic                  empty;
      logic [RANGE_BITS-1:0] first;
      logic [RANGE_BITS-1:0] last;
   } range_type;

endpackage

FILE: hdl/lfrf_config.sv
// Configuration registers and scan range decode.
module lfrf_config (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  lfrf_pkg::csr_index_type             csr_index,
   input  logic [lfrf_pkg::CSR_DATA_BITS-1:0]  csr_write_data,
   output lfrf_pkg::range_type                 range
);
   import lfrf_pkg::*;

   logic [SCAN_BANK_BITS-1:0] scan_bank_ff;
   logic [ROM_BYTES_BITS-1:0] rom_bytes_ff;
   logic                      whole_rom;
   logic [RANGE_BITS-1:0]     bank_first;

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_bank_ff <= SCAN_BANK_RESET;
         rom_bytes_ff <= ROM_BYTES_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_SCAN_BANK: scan_bank_ff <= csr_write_data[SCAN_BANK_BITS-1:0];
            CSR_ROM_BYTES: rom_bytes_ff <= csr_write_data[ROM_BYTES_BITS-1:0];
         endcase
      end
   end

   // Negative bank number means whole ROM.
   assign whole_rom  = scan_bank_ff[SCAN_BANK_BITS-1];
   assign bank_first = RANGE_BITS'(scan_bank_ff[SCAN_BANK_BITS-2:0]) << BANK_BITS;

   always_comb begin
      if (whole_rom) begin
         range.empty = (rom_bytes_ff == '0);
         range.first = '0;
         range.last  = RANGE_BITS'(rom_bytes_ff - ROM_BYTES_BITS'(1));
      end else begin
         range.empty = 1'b0;
         range.first = bank_first;
         range.last  = bank_first + RANGE_BITS'(BANK_BYTES - 1);
      end
   end

endmodule

FILE: hdl/lfrf_tracker.sv
// Run tracker: current run and best run, updated once per processed item.
module lfrf_tracker (
   input  logic                clock,
   input  logic                reset,
   input  lfrf_pkg::range_type range,
   input  lfrf_pkg::req_type   item,
   input  logic                update,
   output logic                emit,
   output lfrf_pkg::rsp_type   result
);
   import lfrf_pkg::*;

   logic                    in_run_ff,      in_run_in;
   logic [ADDRESS_BITS-1:0] run_start_ff,   run_start_in;
   logic [LENGTH_BITS-1:0]  run_length_ff,  run_length_in;
   logic [ADDRESS_BITS-1:0] best_start_ff,  best_start_in;
   logic [LENGTH_BITS-1:0]  best_length_ff, best_length_in;

   logic [RANGE_BITS-1:0] address_wide;
   logic                  in_range;
   logic                  at_first;
   logic                  at_last;
   logic                  filler;

   assign address_wide = RANGE_BITS'(item.rom_address);
   assign in_range = !range.empty && (address_wide >= range.first)
                     && (address_wide <= range.last);
   assign at_first = (address_wide == range.first);
   assign at_last  = (address_wide == range.last);
   // Bank-aligned byte never counts as filler.
   assign filler   = ((item.rom_byte == FILL_ZERO) || (item.rom_byte == FILL_ONES))
                     && (item.rom_address[BANK_BITS-1:0] != '0);

   assign emit = in_range && at_last;

   always_comb begin
      in_run_in      = in_run_ff;
      run_start_in   = run_start_ff;
      run_length_in  = run_length_ff;
      best_start_in  = best_start_ff;
      best_length_in = best_length_ff;

      if (at_first) begin
         in_run_in      = 1'b0;
         run_start_in   = '0;
         run_length_in  = '0;
         best_start_in  = '0;
         best_length_in = '0;
      end

      if (filler) begin
         if (!in_run_in) begin
            run_start_in  = item.rom_address;
            run_length_in = LENGTH_BITS'(1);
            in_run_in     = 1'b1;
         end else if (run_length_in != '1) begin
            run_length_in = run_length_in + LENGTH_BITS'(1);
         end
      end else begin
         if (in_run_in && (run_length_in > best_length_in)) begin
            best_start_in  = run_start_in;
            best_length_in = run_length_in;
         end
         in_run_in = 1'b0;
      end

      // Last address closes any open run.
      if (at_last) begin
         if (in_run_in && (run_length_in > best_length_in)) begin
            best_start_in  = run_start_in;
            best_length_in = run_length_in;
         end
         in_run_in = 1'b0;
      end

      result.longest_start = best_start_in;
      result.longest_size  = best_length_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_run_ff      <= 1'b0;
         run_start_ff   <= '0;
         run_length_ff  <= '0;
         best_start_ff  <= '0;
         best_length_ff <= '0;
      end else if (update && in_range) begin
         in_run_ff      <= in_run_in;
         run_start_ff   <= run_start_in;
         run_length_ff  <= run_length_in;
         best_start_ff  <= best_start_in;
         best_length_ff <= best_length_in;
      end
   end

endmodule

FILE: hdl/longest_fill_run_finder.sv
// Top level of the longest fill run finder: input register, tracker, result register.
//
// Accepts one ROM item (address and byte) per clock cycle, back to back, and
// reports the start and length of the longest run of 0x00/0xFF bytes in the
// configured scan range (one bank, or the whole ROM when scan_bank is
// negative). Items outside the range are dropped; the range's first address
// restarts the search and its last address produces one result item, loaded
// into the output register when that item leaves the input register. Each
// item waits in the input register while the tracker's compare-and-increment
// logic updates the run state. The input side stalls only when the output
// register holds a result that is itself stalled and the item in the input
// register would produce another one. Write the configuration registers only
// while no item is in flight.
module longest_fill_run_finder (
   input  logic                                clock,
   input  logic                                reset,
   // item input
   input  logic                                req_valid,
   output logic                                req_stall,
   input  lfrf_pkg::req_type                   req_item,
   // result output
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output lfrf_pkg::rsp_type                   rsp_item,
   // configuration writes
   input  logic                                csr_write_enable,
   input  lfrf_pkg::csr_index_type             csr_index,
   input  logic [lfrf_pkg::CSR_DATA_BITS-1:0]  csr_write_data
);
   import lfrf_pkg::*;

   range_type range;

   // input register
   logic    s1_valid_ff;
   req_type s1_item_ff;

   // result register
   logic    rsp_valid_ff;
   rsp_type rsp_item_ff;

   logic    emit;
   rsp_type result;
   logic    s1_fire;

   lfrf_config u_config (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .range            (range)
   );

   lfrf_tracker u_tracker (
      .clock  (clock),
      .reset  (reset),
      .range  (range),
      .item   (s1_item_ff),
      .update (s1_valid_ff && s1_fire),
      .emit   (emit),
      .result (result)
   );

   // Item in stage 1 can retire unless it makes a result and the output
   // register is full and stalled.
   assign s1_fire   = !emit || !rsp_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !s1_fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         s1_item_ff <= req_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_valid_ff && s1_fire && emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff && s1_fire && emit) begin
         rsp_item_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

FILE: tb/longest_fill_run_finder_tb.sv
// Self-checking testbench for the longest fill run finder: directed rows, random scans, checks.
module longest_fill_run_finder_tb;
   import lfrf_pkg::*;

   // Cycles to let a result clear the two-stage pipe before touching the CSRs.
   localparam int SETTLE_CYCLES   = 8;
   // Receiver back-pressure long enough to fill the input and output registers.
   localparam int HOLD_OFF_CYCLES = 150;
   // Far beyond the slowest legal run: every gap and stall at MAX_GAP.
   localparam int CYCLE_LIMIT     = 300000;
   localparam int MAX_GAP         = 18;

   // One row of the directed plan. Rows marked typed carry the result that
   // the closing address must produce; the rest go through the predictor.
   typedef struct packed {
      logic [ADDRESS_BITS-1:0] address;
      logic [BYTE_BITS-1:0]    data;
      logic                    typed;
      logic [ADDRESS_BITS-1:0] want_start;
      logic [LENGTH_BITS-1:0]  want_size;
   } plan_row_type;

   // Default setup after reset: whole ROM, 32 KiB, so the range is 0 to 32767.
   localparam int DIRECTED_ROWS = 21;
   localparam plan_row_type DIRECTED_PLAN [DIRECTED_ROWS] = '{
      '{23'd0,       8'h00, 1'b0, 23'd0,     24'd0},  // first address, bank aligned
      '{23'd1,       8'hFF, 1'b0, 23'd0,     24'd0},
      '{23'd2,       8'h00, 1'b0, 23'd0,     24'd0},
      '{23'd3,       8'hFE, 1'b0, 23'd0,     24'd0},  // near-filler ends run of 2
      '{23'd100,     8'h00, 1'b0, 23'd0,     24'd0},
      '{23'd101,     8'hFF, 1'b0, 23'd0,     24'd0},
      '{23'd102,     8'h01, 1'b0, 23'd0,     24'd0},  // equal length, earlier run kept
      '{23'd16382,   8'hFF, 1'b0, 23'd0,     24'd0},
      '{23'd16383,   8'h00, 1'b0, 23'd0,     24'd0},
      '{23'd16384,   8'h00, 1'b0, 23'd0,     24'd0},  // bank boundary breaks the run
      '{23'd16385,   8'hFF, 1'b0, 23'd0,     24'd0},
      '{23'd16386,   8'hFF, 1'b0, 23'd0,     24'd0},
      '{23'd16387,   8'h00, 1'b0, 23'd0,     24'd0},
      '{23'd32768,   8'hFF, 1'b0, 23'd0,     24'd0},  // past the end, dropped
      '{23'd8388607, 8'h00, 1'b0, 23'd0,     24'd0},  // top address, dropped
      '{23'd32767,   8'h00, 1'b1, 23'd16385, 24'd4},  // last address closes open run
      '{23'd0,       8'h80, 1'b0, 23'd0,     24'd0},  // restart
      '{23'd5,       8'h7F, 1'b0, 23'd0,     24'd0},
      '{23'd32767,   8'h00, 1'b1, 23'd32767, 24'd1},  // run on the last byte alone
      '{23'd0,       8'hFF, 1'b0, 23'd0,     24'd0},  // restart
      '{23'd32767,   8'h55, 1'b1, 23'd0,     24'd0}   // no filler at all
   };

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   req_type                   req_item;
   logic                      rsp_valid;
   logic                      rsp_stall;
   rsp_type                   rsp_item;
   logic                      csr_write_enable;
   csr_index_type             csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_write_data;

   // Shadow of the CSRs and of the run tracker.
   logic [SCAN_BANK_BITS-1:0] cfg_scan_bank;
   logic [ROM_BYTES_BITS-1:0] cfg_rom_bytes;
   logic                      fill_open;
   logic [ADDRESS_BITS-1:0]   fill_start;
   logic [LENGTH_BITS-1:0]    fill_len;
   logic [ADDRESS_BITS-1:0]   best_fill_start;
   logic [LENGTH_BITS-1:0]    best_fill_len;

   rsp_type                   expected_runs[$];
   int                        mismatches;
   int                        cycle_count;

   // Pacing knobs. Written by the stimulus at falling edges, read at rising ones.
   bit                        tx_quiet;
   bit                        rx_quiet;
   bit                        hold_off_request;

   longest_fill_run_finder u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_item         (req_item),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_item         (rsp_item),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   //------------------------------------------------------------------
   // Predictor
   //------------------------------------------------------------------

   // Scan window from the shadow CSRs. A negative bank means the whole ROM;
   // a whole-ROM scan of size zero has no window at all. hi can exceed the
   // address space, in which case no closing address ever arrives.
   function automatic void scan_range(output int unsigned lo, output int unsigned hi,
                                      output bit none);
      none = 1'b0;
      if (cfg_scan_bank[SCAN_BANK_BITS-1]) begin
         none = (cfg_rom_bytes == '0);
         lo   = 0;
         hi   = 32'(cfg_rom_bytes) - 1;
      end else begin
         lo = 32'(cfg_scan_bank) * BANK_BYTES;
         hi = lo + BANK_BYTES - 1;
      end
   endfunction

   // Strictly longer wins, so ties keep the earlier run.
   function automatic void close_fill();
      if (fill_open) begin
         if (fill_len > best_fill_len) begin
            best_fill_len   = fill_len;
            best_fill_start = fill_start;
         end
         fill_open = 1'b0;
      end
   endfunction

   // Advances the tracker by one accepted item; returns 1 with the result
   // when the item is the window's closing address.
   function automatic bit predict_longest_fill(input req_type it, output rsp_type res);
      int unsigned lo, hi, addr;
      bit          none;
      res = '0;
      scan_range(lo, hi, none);
      addr = 32'(it.rom_address);
      if (none || addr < lo || addr > hi)
         return 1'b0;
      if (addr == lo) begin
         fill_open       = 1'b0;
         fill_start      = '0;
         fill_len        = '0;
         best_fill_start = '0;
         best_fill_len   = '0;
      end
      // A bank-aligned byte never counts as filler.
      if ((it.rom_byte == FILL_ZERO || it.rom_byte == FILL_ONES) &&
          it.rom_address[BANK_BITS-1:0] != '0) begin
         if (!fill_open) begin
            fill_open  = 1'b1;
            fill_start = it.rom_address;
            fill_len   = 24'd1;
         end else if (fill_len != '1) begin
            fill_len = fill_len + 1'b1;
         end
      end else begin
         close_fill();
      end
      if (addr != hi)
         return 1'b0;
      close_fill();
      res.longest_start = best_fill_start;
      res.longest_size  = best_fill_len;
      return 1'b1;
   endfunction

   //------------------------------------------------------------------
   // Item sources
   //------------------------------------------------------------------

   // Item at a given address with a byte biased toward filler values.
   function automatic req_type rom_item(input int unsigned a);
      req_type it;
      it.rom_address = a[ADDRESS_BITS-1:0];
      if ($urandom_range(0, 9) < 7)
         it.rom_byte = $urandom_range(0, 1) ? FILL_ONES : FILL_ZERO;
      else
         it.rom_byte = 8'($urandom_range(0, 255));
      return it;
   endfunction

   // Noise: just outside the window on either side, or anywhere at all.
   function automatic req_type stray_item(input int unsigned lo, input int unsigned hi);
      int unsigned a;
      case ($urandom_range(0, 2))
         0: a = hi + $urandom_range(1, 4);
         1: a = (lo > 4) ? lo - $urandom_range(1, 4) : hi + 1;
         default: a = $urandom();
      endcase
      return rom_item(a);
   endfunction

   //------------------------------------------------------------------
   // Driver side. All calls start and end on a falling edge. valid stays
   // high between back-to-back items so that it only gets one update per
   // edge.
   //------------------------------------------------------------------

   task automatic send_item(input req_type it, input bit typed = 1'b0,
                            input rsp_type typed_want = '0);
      int      gap;
      rsp_type res;
      gap = tx_quiet ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= it;
      do @(posedge clock); while (req_stall);
      if (predict_longest_fill(it, res))
         expected_runs.push_back(typed ? typed_want : res);
      @(negedge clock);
   endtask

   // Stop sending and wait until every result is out, plus some slack for
   // items still in the pipe that produce nothing.
   task automatic quiesce();
      req_valid <= 1'b0;
      do @(negedge clock); while (expected_runs.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // CSR update between phases; the block is idle when the writes land.
   task automatic configure(input bit set_bank, input int bank,
                            input bit set_size, input int size);
      quiesce();
      if (set_bank) begin
         csr_write_enable <= 1'b1;
         csr_index        <= CSR_SCAN_BANK;
         csr_write_data   <= 24'(bank);
         cfg_scan_bank     = 10'(bank);
         @(negedge clock);
      end
      if (set_size) begin
         csr_write_enable <= 1'b1;
         csr_index        <= CSR_ROM_BYTES;
         csr_write_data   <= 24'(size);
         cfg_rom_bytes     = 24'(size);
         @(negedge clock);
      end
      csr_write_enable <= 1'b0;
   endtask

   // Random scans over the current window. Most are well formed: opening
   // address, a short walk forward (single steps, hops to just before or on
   // a bank boundary, longer jumps, repeats), then the closing address.
   // Some drop the opening or the closing address, some are pure noise, and
   // some first wait for the pipe to drain.
   task automatic scan_sequences(input int budget);
      int unsigned lo, hi, at;
      bit          none;
      int          sent, steps, kind;
      sent = 0;
      scan_range(lo, hi, none);
      while (sent < budget) begin
         tx_quiet = ($urandom_range(0, 3) == 0);
         rx_quiet = ($urandom_range(0, 3) == 0);
         kind     = $urandom_range(0, 9);
         if (none || kind == 0) begin
            repeat (3) begin
               send_item(stray_item(lo, hi));
               sent++;
            end
         end else begin
            if (kind == 1) begin
               req_valid <= 1'b0;
               do @(negedge clock); while (expected_runs.size() != 0);
            end
            at = lo;
            if (kind != 2) begin
               send_item(rom_item(at));
               sent++;
            end
            steps = $urandom_range(1, 14);
            while (steps > 0) begin
               steps--;
               case ($urandom_range(0, 9))
                  0, 1, 2, 3, 4, 5: at = at + 1;
                  6, 7: at = ((at / BANK_BYTES) + 1) * BANK_BYTES - $urandom_range(0, 2);
                  8: at = at + $urandom_range(2, 3000);
                  default: ;  // same address again
               endcase
               if (at >= hi)
                  break;
               send_item(rom_item(at));
               sent++;
            end
            if (kind != 3) begin
               send_item(rom_item(hi));
               sent++;
            end
         end
      end
   endtask

   //------------------------------------------------------------------
   // Receiver pacing. After each result it stalls a random number of
   // cycles; on request it holds off for a long stretch instead, once.
   //------------------------------------------------------------------
   initial begin : result_pacing
      int left;
      bit hold_done;
      left      = 0;
      hold_done = 1'b0;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_request && !hold_done) begin
            hold_done = 1'b1;
            left = HOLD_OFF_CYCLES;
         end else if (rsp_valid === 1'b1 && !rsp_stall) begin
            left = rx_quiet ? 0 : $urandom_range(0, MAX_GAP);
         end else if (left > 0) begin
            left--;
         end
         @(negedge clock);
         rsp_stall <= (left != 0);
      end
   end

   //------------------------------------------------------------------
   // Result checker
   //------------------------------------------------------------------
   always @(posedge clock) begin : result_check
      rsp_type want;
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (expected_runs.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected result, expected none, got start %0d size %0d",
                     $time, rsp_item.longest_start, rsp_item.longest_size);
         end else begin
            want = expected_runs.pop_front();
            if (rsp_item.longest_start !== want.longest_start) begin
               mismatches++;
               $display("%0t: longest_start expected %0d got %0d",
                        $time, want.longest_start, rsp_item.longest_start);
            end
            if (rsp_item.longest_size !== want.longest_size) begin
               mismatches++;
               $display("%0t: longest_size expected %0d got %0d",
                        $time, want.longest_size, rsp_item.longest_size);
            end
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   //------------------------------------------------------------------
   // Stimulus
   //------------------------------------------------------------------
   initial begin : stimulus
      req_type      it;
      rsp_type      want;
      plan_row_type row;
      int unsigned  lo, hi;
      bit           none;

      reset            = 1'b1;
      req_valid        = 1'b0;
      req_item         = '0;
      csr_write_enable = 1'b0;
      csr_index        = CSR_SCAN_BANK;
      csr_write_data   = '0;
      tx_quiet         = 1'b0;
      rx_quiet         = 1'b0;
      hold_off_request = 1'b0;

      cfg_scan_bank    = SCAN_BANK_RESET;
      cfg_rom_bytes    = ROM_BYTES_RESET;
      fill_open        = 1'b0;
      fill_start       = '0;
      fill_len         = '0;
      best_fill_start  = '0;
      best_fill_len    = '0;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed rows against the reset setup.
      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         row                = DIRECTED_PLAN[i];
         it.rom_address     = row.address;
         it.rom_byte        = row.data;
         want.longest_start = row.want_start;
         want.longest_size  = row.want_size;
         send_item(it, row.typed, want);
      end
      scan_sequences(60);

      // Single banks: lowest, highest, then one in between.
      configure(1'b1, 0, 1'b0, 0);
      scan_sequences(60);
      configure(1'b1, 511, 1'b0, 0);
      scan_sequences(60);
      configure(1'b1, $urandom_range(1, 510), 1'b0, 0);

      // Long receiver hold while items keep coming back to back: opening and
      // closing address pairs make a result every other item, so both
      // registers fill and the input side has to stall.
      scan_range(lo, hi, none);
      hold_off_request = 1'b1;
      tx_quiet         = 1'b1;
      repeat (12) begin
         send_item(rom_item(lo));
         send_item(rom_item(hi));
      end
      scan_sequences(60);

      // Most negative bank selects the whole ROM; largest ROM that still fits.
      configure(1'b1, -512, 1'b1, 8388608);
      scan_sequences(60);
      // Back to the reset values, then an odd ROM size.
      configure(1'b1, -1, 1'b1, 32768);
      scan_sequences(60);
      configure(1'b0, 0, 1'b1, $urandom_range(32769, 100000));
      scan_sequences(60);

      // Empty window: every item is dropped.
      configure(1'b0, 0, 1'b1, 0);
      scan_sequences(30);
      // Window ends past the top address: nothing ever closes.
      configure(1'b0, 0, 1'b1, 16777215);
      scan_sequences(30);

      // Random negative bank, random size.
      configure(1'b1, -$urandom_range(2, 511), 1'b1, $urandom_range(32768, 8388608));
      scan_sequences(60);
      configure(1'b1, $urandom_range(0, 511), 1'b0, 0);
      scan_sequences(60);

      quiesce();
      if (mismatches == 0 && expected_runs.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

FILE: filelist.f
hdl/lfrf_pkg.sv
hdl/lfrf_config.sv
hdl/lfrf_tracker.sv
hdl/longest_fill_run_finder.sv
tb/longest_fill_run_finder_tb.sv
